// File: hw/rtl/sha_pkg.sv
// Shared types, round constants and sigma functions for the SHA-256 engine.
// No dependencies; sha_core and the top level of the engine import this package.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Index 0 is word a (most significant digest word).
  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/sha_core.sv
// SHA-256 compression unit: one round per cycle, schedule window in registers.
// Reads block words from the block RAM; uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        init,
  input  wire logic        start,
  input  wire logic [31:0] rdata,
  output      logic [3:0]  raddr,
  output      core_stat_t  stat,
  output      hash_t       hash
);

  logic             run;
  logic [6:0]       rnd;
  hash_t            wv;
  logic [15:0][31:0] win;
  logic [31:0]      w_cur;
  logic [31:0]      t1;
  logic [31:0]      t2;
  logic [31:0]      ch;
  logic [31:0]      maj;

  // Read word r+1 during round r so it arrives for the next round.
  assign raddr = run ? (rnd[3:0] + 4'd1) : 4'd0;

  assign stat.busy = run;
  assign stat.done = run && rnd[6];

  always_comb begin
    if (rnd[6:4] == 3'd0) begin
      w_cur = rdata;
    end else begin
      w_cur = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    end
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1  = wv[7] + big_sigma1(wv[4]) + ch + ROUND_K[rnd[5:0]] + w_cur;
    t2  = big_sigma0(wv[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      rnd <= '0;
    end else if (start) begin
      run <= 1'b1;
      rnd <= '0;
    end else if (run) begin
      if (rnd[6]) begin
        run <= 1'b0;
      end else begin
        rnd <= rnd + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      hash <= INIT_HASH;
    end else if (run && rnd[6]) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + wv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      wv <= hash;
    end else if (run && !rnd[6]) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_cur;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !run)
    else $error("compression started while busy");
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
      run |-> (rnd <= 7'd64))
    else $error("round counter out of range");
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
      stat.done |=> !run)
    else $error("core kept running after done");

endmodule
`default_nettype wire

// File: hw/rtl/sha256_hash_engine.sv
// Top level of the SHA-256 engine: block buffering, padding and digest output.
// Uses sha_pkg, sha_ram (block buffer) and sha_core (compression).
//
//   channel | signals                      | direction | payload
//   in      | in_valid, in_stall, in_data  | into      | in_req_t
//   out     | out_valid, out_stall, out_data | out of  | out_req_t
//
// Message words fill the block buffer; every 16th word starts a compression
// in sha_core, during which in_stall is high.
// The final word adds pad and length words at one per cycle outside compression,
// with one or two compressions, then eight digest words are shown one per accepted request.
// rst is synchronous and restores the initial hash and an empty block.
// out_stall holds the current digest word; in_stall is high outside idle.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_engine
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire in_req_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_stall,
  output      out_req_t out_data
);

  state_t      state;
  state_t      state_next;
  state_t      ret_state;
  state_t      ret_state_next;
  logic [3:0]  fill;
  logic [60:0] msg_bytes;
  logic        pad_pending;
  logic        len_phase;
  logic [2:0]  out_idx;

  logic        push;
  logic [31:0] push_word;
  logic        push_lo;
  logic        push_hi;
  logic        in_take;
  logic        out_take;
  logic        core_start;
  logic        hash_init;
  logic [2:0]  nb_sat;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  core_stat_t  stat;
  hash_t       hash;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign nb_sat   = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    push           = 1'b0;
    push_word      = '0;
    push_lo        = 1'b0;
    push_hi        = 1'b0;
    core_start     = 1'b0;
    hash_init      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_take) begin
          push = 1'b1;
          if (!in_data.end_of_message) begin
            push_word = in_data.data_word;
          end else begin
            unique case (nb_sat)
              3'd0:    push_word = PAD_WORD;
              3'd1:    push_word = {in_data.data_word[31:24], 24'h80_0000};
              3'd2:    push_word = {in_data.data_word[31:16], 16'h8000};
              3'd3:    push_word = {in_data.data_word[31:8], 8'h80};
              default: push_word = in_data.data_word;
            endcase
            state_next = ST_PAD;
          end
          ret_state_next = in_data.end_of_message ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        push = 1'b1;
        priority if (pad_pending) begin
          push_word = PAD_WORD;
        end else if (fill == 4'd14) begin
          push_hi   = 1'b1;
          push_word = msg_bytes[60:29];
        end else if (fill == 4'd15 && len_phase) begin
          push_lo   = 1'b1;
          push_word = {msg_bytes[28:0], 3'b000};
        end else begin
          push_word = '0;
        end
        ret_state_next = push_lo ? ST_OUT : ST_PAD;
      end
      ST_COMP: begin
        if (stat.done) begin
          state_next = ret_state;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_take && out_idx == 3'd7) begin
          hash_init  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // A full buffer hands off to the compression unit.
    if (push && fill == 4'd15) begin
      core_start = 1'b1;
      state_next = ST_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      msg_bytes   <= '0;
      pad_pending <= 1'b0;
      len_phase   <= 1'b0;
      out_idx     <= '0;
    end else begin
      if (push) begin
        fill <= fill + 4'd1;
      end
      if (in_take) begin
        msg_bytes   <= msg_bytes + (in_data.end_of_message ? 61'(nb_sat) : 61'd4);
        pad_pending <= in_data.end_of_message && nb_sat == 3'd4;
      end else if (state == ST_PAD) begin
        pad_pending <= 1'b0;
      end
      if (push_hi) begin
        len_phase <= 1'b1;
      end
      // The index wraps back to zero on the eighth word.
      if (out_take) begin
        out_idx <= out_idx + 3'd1;
      end
      if (hash_init) begin
        msg_bytes <= '0;
        len_phase <= 1'b0;
      end
    end
  end

  assign out_data.digest_word = hash[out_idx];
  assign out_data.word_index  = out_idx;
  assign out_data.last_word   = (out_idx == 3'd7);

  sha_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block_ram (
    .clk  (clk),
    .we   (push),
    .waddr(fill),
    .wdata(push_word),
    .raddr(raddr),
    .rdata(rdata)
  );

  sha_core u_core (
    .clk  (clk),
    .rst  (rst),
    .init (hash_init),
    .start(core_start),
    .rdata(rdata),
    .raddr(raddr),
    .stat (stat),
    .hash (hash)
  );

  a_start_free: assert property (@(posedge clk) disable iff (rst)
      core_start |-> !stat.busy)
    else $error("block handed off while compression busy");
  a_out_empty: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (fill == 4'd0 && len_phase && !stat.busy))
    else $error("digest shown with block data pending");
  a_pad_state: assert property (@(posedge clk) disable iff (rst)
      pad_pending |-> (state == ST_PAD || state == ST_COMP))
    else $error("pad word pending outside padding");
  a_no_push_comp: assert property (@(posedge clk) disable iff (rst)
      stat.busy |-> !push)
    else $error("block buffer written during compression");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for sha256_hash_engine: streams message words, predicts
// each digest with a behavioral SHA-256 and compares every digest word.
// Depends on sha_pkg and the engine RTL only.
`timescale 1ns / 1ps
module testbench;
  import sha_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic bool_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;

  always #10 clk = ~clk;

  sha256_hash_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Digest predictor state
  logic [31:0] k_tab [64];
  logic [31:0] h_st [8];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [60:0] msg_bytes;
  out_req_t    digest_q [$];

  int errors = 0;
  int words_sent = 0;
  int digests_seen = 0;
  int idle_cycles = 0;
  bool_t quiet;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    a = h_st[0]; b = h_st[1]; c = h_st[2]; d = h_st[3];
    e = h_st[4]; f = h_st[5]; g = h_st[6]; h = h_st[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + k_tab[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h_st[0] += a; h_st[1] += b; h_st[2] += c; h_st[3] += d;
    h_st[4] += e; h_st[5] += f; h_st[6] += g; h_st[7] += h;
  endtask

  task automatic push_block_word(input logic [31:0] w);
    blk[fill] = w;
    fill = (fill + 1) % 16;
    if (fill == 0) compress();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) h_st[i] = INIT_HASH[i];
    fill = 0;
    msg_bytes = '0;
  endtask

  task automatic predict_word(input in_req_t r);
    int unsigned nb;
    logic [31:0] mask;
    logic [63:0] bits;
    out_req_t o;
    if (!r.end_of_message) begin
      msg_bytes += 61'd4;
      push_block_word(r.data_word);
      return;
    end
    nb = (r.valid_bytes > 4) ? 4 : r.valid_bytes;
    msg_bytes += 61'(nb);
    if (nb == 4) begin
      push_block_word(r.data_word);
      push_block_word(PAD_WORD);
    end else begin
      mask = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      push_block_word((r.data_word & mask) | (32'h80 << (24 - 8 * nb)));
    end
    while (fill != 14) push_block_word(32'h0);
    bits = {msg_bytes, 3'b000};
    push_block_word(bits[63:32]);
    push_block_word(bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      o.digest_word = h_st[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_q.push_back(o);
    end
    restart_hash();
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Compare each accepted digest word with the oldest expectation
  always @(posedge clk) begin
    out_req_t want;
    if (!rst && out_valid && !out_stall) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        report("unexpected digest word", out_data.digest_word, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // Receiver stalls, except during a quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 6);
  end

  // Watchdog on accepted requests
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d digest words pending", digest_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Leave valid high on return; the next call or the caller drops it.
  task automatic send_word(input logic [31:0] d, input logic [2:0] nb,
                           input logic eom);
    in_req_t r;
    r.data_word = d;
    r.valid_bytes = nb;
    r.end_of_message = eom;
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(r);
    words_sent++;
  endtask

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nb;
    logic        eom;
  } stim_row_t;

  // Directed rows: extremes, every valid byte count, empty and two-word messages
  stim_row_t stim_tab [] = '{
    '{32'h0000_0000, 3'd0, 1'b1},   // empty message
    '{32'h6162_6300, 3'd3, 1'b1},   // "abc"
    '{32'hFFFF_FFFF, 3'd1, 1'b1},
    '{32'hFFFF_FFFF, 3'd2, 1'b1},
    '{32'hFFFF_FFFF, 3'd4, 1'b1},
    '{32'hFFFF_FFFF, 3'd7, 1'b1},   // count above four acts as four
    '{32'hA5A5_A5A5, 3'd5, 1'b1},
    '{32'h1234_5678, 3'd6, 1'b0},   // count ignored on a middle word
    '{32'hFFFF_FFFF, 3'd0, 1'b1}    // tail bytes dropped for the pad
  };

  // "abc" digest, word 0 and word 7
  localparam logic [31:0] ABC_D0 = 32'hba7816bf;
  localparam logic [31:0] ABC_D7 = 32'hf20015ad;

  initial begin
    int n_msgs, len;
    k_tab = ROUND_K;
    restart_hash();
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_tab[i]) begin
      send_word(stim_tab[i].data, stim_tab[i].nb, stim_tab[i].eom);
      // the newest eight expectations belong to "abc"
      if (i == 1 && (digest_q[digest_q.size() - 8].digest_word !== ABC_D0
                     || digest_q[digest_q.size() - 1].digest_word !== ABC_D7))
        report("abc predictor", digest_q[digest_q.size() - 8].digest_word, ABC_D0);
    end
    // messages that cross block boundaries: 13..16 full words
    for (int m = 13; m <= 16; m++) begin
      for (int j = 0; j < m; j++) send_word($urandom, 3'($urandom), 1'b0);
      send_word($urandom, 3'(m % 5), 1'b1);
    end

    // random messages, mostly short, a few several blocks long
    while (words_sent < 450) begin
      quiet = (words_sent > 250 && words_sent < 330);
      len = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(18);
      for (int j = 0; j < len; j++) send_word($urandom, 3'($urandom), 1'b0);
      send_word($urandom, 3'($urandom), 1'b1);
      n_msgs++;
    end
    in_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d message words incl. %0d random messages", words_sent, n_msgs);
    $display("checked %0d digest words, %0d mismatches", digests_seen, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
